@@ src/bpfa_pkg.sv @@
// Shared types, constants and helpers for the bitmap page frame allocator.
// No dependencies; every other source file imports this package.
package bpfa_pkg;

  // bitmap word geometry
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

  // default frame total
  localparam int NUM_FRAMES_DEF = 4096;

  // payload field widths
  localparam int OP_W  = 2;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RESERVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_RGN,
    ST_FIX_RD,
    ST_FIX_WR,
    ST_RESP
  } state_t;

  // index of the lowest clear bit (only meaningful when one exists)
  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  // ones from bit lo up to bit hi inclusive
  function automatic logic [WORD_BITS-1:0] range_mask(input logic [BIT_W-1:0] lo,
                                                      input logic [BIT_W-1:0] hi);
    logic [BIT_W-1:0] top_gap;
    top_gap = BIT_W'(WORD_BITS - 1) - hi;
    return (ALL_ONES << lo) & (ALL_ONES >> top_gap);
  endfunction

endpackage

@@ src/bpfa_if.sv @@
// Request and response channel interfaces for the page frame allocator.
// Depends on bpfa_pkg for the payload field widths.
interface bpfa_req_if;
  import bpfa_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] frame_index;
  logic [CNT_W-1:0] frame_count;

  modport source (output valid, op, frame_index, frame_count, input ready);
  modport sink   (input valid, op, frame_index, frame_count, output ready);
endinterface

interface bpfa_rsp_if;
  import bpfa_pkg::*;
  logic             valid;
  logic             ready;
  logic             ok;
  logic [IDX_W-1:0] granted_frame;
  logic [CNT_W-1:0] frames_in_use;

  modport source (output valid, ok, granted_frame, frames_in_use, input ready);
  modport sink   (input valid, ok, granted_frame, frames_in_use, output ready);
endinterface

@@ src/bpfa_ram.sv @@
// Bitmap word store: one write port, one read port, registered read data.
// Depends on bpfa_pkg for the word width.
module bpfa_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [bpfa_pkg::WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]                  raddr,
  output logic [bpfa_pkg::WORD_BITS-1:0] rdata
);
  import bpfa_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/bitmap_page_frame_allocator.sv @@
// Bitmap page frame allocator: sequencer, counter and response register.
// Depends on bpfa_pkg, bpfa_if (channels) and bpfa_ram (bitmap store).
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   op, frame_index, frame_count
//   rsp      out  valid/ready   ok, granted_frame, frames_in_use
//
// One word at a time: an allocation runs a first-fit scan over the bitmap RAM read
// port (one word per cycle, pipelined). Free, release and reserve walk each bitmap
// word their region touches, none for an empty region; release then also sets
// frame 0 again. After reset a clearing pass fills every bitmap word with ones; no
// word is accepted during it. req is ready only between operations; a finished
// result waits in the rsp register while the next word is taken.
module bitmap_page_frame_allocator #(
  parameter int NUM_FRAMES = bpfa_pkg::NUM_FRAMES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bpfa_req_if.sink    req,
  bpfa_rsp_if.source  rsp
);
  import bpfa_pkg::*;

  localparam int NUM_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CW        = $clog2(NUM_FRAMES + 1);
  localparam int FW        = $clog2(NUM_FRAMES);
  localparam int XW        = ((CW > CNT_W) ? CW : CNT_W) + 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);
  localparam logic [XW-1:0] NF_X      = XW'(NUM_FRAMES);
  localparam logic [CW-1:0] NF_C      = CW'(NUM_FRAMES);

  state_t state, state_next;

  op_t               op_r;
  logic [XW-1:0]     start_r;
  logic [XW-1:0]     end_r;      // end frame, then last frame after setup
  logic [AW-1:0]     fw_r;
  logic [AW-1:0]     lw_r;
  logic [AW-1:0]     rd_addr;
  logic              rd_go;
  logic              chk_valid;
  logic [AW-1:0]     chk_addr;
  logic [CW-1:0]     used;
  logic              ok_r;
  logic [FW-1:0]     grant_r;

  logic              rsp_valid;
  logic              rsp_ok;
  logic [IDX_W-1:0]  rsp_grant;
  logic [CNT_W-1:0]  rsp_used;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WORD_BITS-1:0] wdata;
  logic [AW-1:0]        raddr;
  logic [WORD_BITS-1:0] rdata;

  bpfa_ram #(.DEPTH(NUM_WORDS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // checks on the word read back
  logic             word_full;
  logic [BIT_W-1:0] fz;
  logic [XW-1:0]    found_f;
  logic             found_ok;
  logic [BIT_W-1:0] lo;
  logic [BIT_W-1:0] hi;
  logic [WORD_BITS-1:0] mask;
  logic [CW-1:0]    k;
  logic [CW:0]      up_sum;
  logic             rgn_empty;
  logic [XW-1:0]    end_c;
  logic [XW-1:0]    last_f;
  logic             resp_load;

  always_comb begin
    word_full = (rdata == ALL_ONES);
    fz        = first_zero(rdata);
    found_f   = XW'({chk_addr, fz});
    found_ok  = !word_full && (found_f < NF_X);
    lo        = (chk_addr == fw_r) ? start_r[BIT_W-1:0] : '0;
    hi        = (chk_addr == lw_r) ? end_r[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);
    mask      = range_mask(lo, hi);
    k         = CW'(hi) - CW'(lo) + CW'(1);
    up_sum    = (CW + 1)'(used) + (CW + 1)'(k);
    rgn_empty = (start_r >= NF_X) || (end_r == start_r);
    end_c     = (end_r > NF_X) ? NF_X : end_r;
    last_f    = end_c - XW'(1);
    resp_load = !rsp_valid || rsp.ready;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (rd_addr == LAST_WORD) state_next = ST_IDLE;
      ST_IDLE: begin
        if (req.valid) begin
          if (op_t'(req.op) == OP_ALLOC) state_next = (used >= NF_C) ? ST_RESP : ST_SCAN;
          else                           state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (rgn_empty) state_next = (op_r == OP_RELEASE) ? ST_FIX_RD : ST_RESP;
        else           state_next = ST_RGN;
      end
      ST_SCAN: begin
        if (chk_valid && (!word_full || chk_addr == LAST_WORD)) state_next = ST_RESP;
      end
      ST_RGN: begin
        if (chk_valid && chk_addr == lw_r)
          state_next = (op_r == OP_RELEASE) ? ST_FIX_RD : ST_RESP;
      end
      ST_FIX_RD: state_next = ST_FIX_WR;
      ST_FIX_WR: state_next = ST_RESP;
      ST_RESP:   if (resp_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    we    = 1'b0;
    waddr = chk_addr;
    wdata = rdata;
    raddr = rd_addr;
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = rd_addr;
        wdata = ALL_ONES;
      end
      ST_SCAN: begin
        we    = chk_valid && found_ok;
        wdata = rdata | (WORD_BITS'(1) << fz);
      end
      ST_RGN: begin
        we    = chk_valid;
        wdata = (op_r == OP_RESERVE) ? (rdata | mask) : (rdata & ~mask);
      end
      ST_FIX_RD: raddr = '0;
      ST_FIX_WR: begin
        we    = 1'b1;
        waddr = '0;
        wdata = rdata | WORD_BITS'(1);
      end
      default: ;
    endcase
  end

  assign req.ready         = (state == ST_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.ok            = rsp_ok;
  assign rsp.granted_frame = rsp_grant;
  assign rsp.frames_in_use = rsp_used;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rd_addr   <= '0;
      rd_go     <= 1'b0;
      chk_valid <= 1'b0;
      used      <= NF_C;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= rd_go && (state == ST_SCAN || state == ST_RGN);
      // response word loads when the register is free or being taken
      if (state == ST_RESP && resp_load) rsp_valid <= 1'b1;
      else if (rsp.ready)                rsp_valid <= 1'b0;
      case (state)
        ST_CLEAR: rd_addr <= rd_addr + AW'(1);
        ST_IDLE: begin
          rd_addr <= '0;
          rd_go   <= 1'b1;
        end
        ST_SETUP: begin
          rd_addr <= AW'(start_r >> BIT_W);
          rd_go   <= 1'b1;
        end
        ST_SCAN: begin
          if (rd_go) begin
            rd_addr <= rd_addr + AW'(1);
            if (rd_addr == LAST_WORD) rd_go <= 1'b0;
          end
          if (chk_valid && found_ok) used <= used + CW'(1);
        end
        ST_RGN: begin
          if (rd_go) begin
            rd_addr <= rd_addr + AW'(1);
            if (rd_addr == lw_r) rd_go <= 1'b0;
          end
          // saturating count, one word of frames at a time
          if (chk_valid) begin
            if (op_r == OP_RESERVE) used <= (up_sum > (CW + 1)'(NF_C)) ? NF_C : up_sum[CW-1:0];
            else                    used <= (used >= k) ? (used - k) : '0;
          end
        end
        default: ;
      endcase
    end
  end

  // operation and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          op_r    <= op_t'(req.op);
          start_r <= XW'(req.frame_index);
          end_r   <= XW'(req.frame_index) +
                     ((op_t'(req.op) == OP_FREE) ? XW'(1) : XW'(req.frame_count));
          ok_r    <= !(op_t'(req.op) == OP_ALLOC && used >= NF_C);
          grant_r <= '0;
        end
      end
      ST_SETUP: begin
        end_r <= last_f;
        fw_r  <= AW'(start_r >> BIT_W);
        lw_r  <= AW'(last_f >> BIT_W);
      end
      ST_SCAN: begin
        if (chk_valid) begin
          if (found_ok)                                       grant_r <= FW'(found_f);
          else if (!word_full || chk_addr == LAST_WORD)       ok_r    <= 1'b0;
        end
      end
      ST_RESP: begin
        if (resp_load) begin
          rsp_ok    <= ok_r;
          rsp_grant <= IDX_W'(grant_r);
          rsp_used  <= CNT_W'(used);
        end
      end
      default: ;
    endcase
    if (state == ST_SCAN || state == ST_RGN) chk_addr <= rd_addr;
  end

endmodule

@@ src/bpfa_checker.sv @@
// Port-level checks for the page frame allocator, attached by bind.
// Depends on bpfa_pkg and on the top level's port names.
module bpfa_checker #(
  parameter int NUM_FRAMES = bpfa_pkg::NUM_FRAMES_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic                        rsp_ok,
  input logic [bpfa_pkg::IDX_W-1:0]  rsp_grant,
  input logic [bpfa_pkg::CNT_W-1:0]  rsp_used
);
  import bpfa_pkg::*;

  // words taken in but not yet answered
  logic [1:0] pending;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) pending <= '0;
    else     pending <= pending + 2'(req_fire) - 2'(rsp_fire);
  end

  // a stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) && $stable(rsp_grant)
                                && $stable(rsp_used))
    else $error("response word changed while stalled");

  // no response without an outstanding request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response word with no request outstanding");

  // one operation in work plus one waiting result at most
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more than two words outstanding");

  // a failed allocation grants nothing
  a_fail_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ok |-> rsp_grant == '0)
    else $error("failed allocation reports a frame");

  // used count never exceeds the frame total
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (NUM_FRAMES < 8192) |-> 32'(rsp_used) <= 32'(NUM_FRAMES))
    else $error("frames_in_use above frame total");

endmodule

bind bitmap_page_frame_allocator bpfa_checker #(.NUM_FRAMES(NUM_FRAMES)) u_bpfa_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_ok    (rsp.ok),
  .rsp_grant (rsp.granted_frame),
  .rsp_used  (rsp.frames_in_use)
);

@@ bench/bitmap_page_frame_allocator_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for bitmap_page_frame_allocator: directed and random request words,
// each reply checked against an in-bench bitmap and used-frame counter.
// Depends on bpfa_pkg, bpfa_if and the allocator RTL.
module bitmap_page_frame_allocator_tb;
  import bpfa_pkg::*;

  localparam int NUM_FRAMES = NUM_FRAMES_DEF;
  localparam int NUM_WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int RANDOM_WORDS = 1180;
  localparam int DRAIN_EVERY  = 240;

  typedef struct {
    op_t              op;
    logic [IDX_W-1:0] frame_index;
    logic [CNT_W-1:0] frame_count;
    bit               drain;
  } frame_request_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] granted_frame;
    logic [CNT_W-1:0] frames_in_use;
  } frame_reply_t;

  logic clk;
  logic rst;

  bpfa_req_if req_ch ();
  bpfa_rsp_if rsp_ch ();

  bitmap_page_frame_allocator #(.NUM_FRAMES(NUM_FRAMES)) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // shadow of the allocator state
  logic [WORD_BITS-1:0] frame_map [NUM_WORDS];
  int                   frames_used;

  frame_request_t request_backlog[$];
  frame_reply_t   awaited_replies[$];

  int error_count;
  int words_issued;
  int words_taken;
  int replies_taken;
  int replies_seen;
  int send_pause;
  int recv_stall;
  bit send_calm;
  bit recv_calm;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int draw_pause(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 16));
  endfunction

  // lowest clear frame, full words skipped; -1 when there is none
  function automatic int lowest_clear_frame();
    int f;
    f = -1;
    for (int w = 0; w < NUM_WORDS && f < 0; w++) begin
      if (frame_map[w] != ALL_ONES) begin
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
          if (!frame_map[w][b]) f = w * WORD_BITS + b;
        end
      end
    end
    return (f >= NUM_FRAMES) ? -1 : f;
  endfunction

  function automatic void mark_frame(input int f, input logic used);
    frame_map[f / WORD_BITS][f % WORD_BITS] = used;
    if (used) begin
      if (frames_used < NUM_FRAMES) frames_used++;
    end else begin
      if (frames_used > 0) frames_used--;
    end
  endfunction

  // apply one request word to the shadow state and return the reply it earns
  function automatic frame_reply_t apply_to_bitmap(input op_t op,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic [CNT_W-1:0] cnt);
    frame_reply_t r;
    int f;
    r.ok = 1'b1;
    r.granted_frame = '0;
    case (op)
      OP_ALLOC: begin
        f = lowest_clear_frame();
        if (frames_used >= NUM_FRAMES || f < 0) begin
          r.ok = 1'b0;
        end else begin
          mark_frame(f, 1'b1);
          r.granted_frame = IDX_W'(f);
        end
      end
      OP_FREE: begin
        if (int'(idx) < NUM_FRAMES) mark_frame(int'(idx), 1'b0);
      end
      default: begin
        for (int i = 0; i < int'(cnt) && int'(idx) + i < NUM_FRAMES; i++) begin
          mark_frame(int'(idx) + i, op == OP_RESERVE);
        end
        // frame 0 stays reserved, counter untouched
        if (op == OP_RELEASE) frame_map[0][0] = 1'b1;
      end
    endcase
    r.frames_in_use = CNT_W'(frames_used);
    return r;
  endfunction

  task automatic add_request(input op_t op, input int idx, input int cnt, input bit drain);
    frame_request_t item;
    item.op = op;
    item.frame_index = IDX_W'(idx);
    item.frame_count = CNT_W'(cnt);
    item.drain = drain;
    request_backlog.push_back(item);
  endtask

  // request driver
  always @(negedge clk) begin
    frame_request_t item;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (words_issued == words_taken) begin
      if (send_pause > 0) begin
        send_pause--;
        req_ch.valid <= 1'b0;
      end else if (request_backlog.size() != 0 &&
                   !(request_backlog[0].drain && awaited_replies.size() != 0)) begin
        item = request_backlog.pop_front();
        req_ch.valid       <= 1'b1;
        req_ch.op          <= item.op;
        req_ch.frame_index <= item.frame_index;
        req_ch.frame_count <= item.frame_count;
        words_issued++;
        if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
        send_pause = draw_pause(send_calm);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // reply receiver: stall drawn after every word taken
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (replies_seen != replies_taken) begin
        replies_seen = replies_taken;
        if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
        recv_stall = draw_pause(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: check replies first, then predict newly taken requests
  always @(posedge clk) begin
    frame_reply_t want;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        replies_taken++;
        if (awaited_replies.size() == 0) begin
          flag_mismatch($sformatf("reply with none awaited: ok=%0b frame=%0d used=%0d",
                                  rsp_ch.ok, rsp_ch.granted_frame, rsp_ch.frames_in_use));
        end else begin
          want = awaited_replies.pop_front();
          if (rsp_ch.ok !== want.ok)
            flag_mismatch($sformatf("ok: got %0b want %0b", rsp_ch.ok, want.ok));
          if (rsp_ch.granted_frame !== want.granted_frame)
            flag_mismatch($sformatf("granted_frame: got %0d want %0d",
                                    rsp_ch.granted_frame, want.granted_frame));
          if (rsp_ch.frames_in_use !== want.frames_in_use)
            flag_mismatch($sformatf("frames_in_use: got %0d want %0d",
                                    rsp_ch.frames_in_use, want.frames_in_use));
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        awaited_replies.push_back(apply_to_bitmap(op_t'(req_ch.op), req_ch.frame_index,
                                                  req_ch.frame_count));
        words_taken++;
      end
    end
  end

  // stimulus and end of run
  initial begin
    int sel;
    int idx;
    int cnt;
    int wait_cycles;
    bit drain;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_ALLOC;
    req_ch.frame_index = '0;
    req_ch.frame_count = '0;
    rsp_ch.ready = 1'b0;
    error_count = 0;
    words_issued = 0;
    words_taken = 0;
    replies_taken = 0;
    replies_seen = 0;
    send_pause = 0;
    recv_stall = 0;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    for (int w = 0; w < NUM_WORDS; w++) frame_map[w] = ALL_ONES;
    frames_used = NUM_FRAMES;

    // directed: counter full, empty regions, double free, no free bit, saturation
    add_request(OP_ALLOC, 0, 0, 1'b0);
    add_request(OP_RELEASE, 0, 0, 1'b0);
    add_request(OP_RESERVE, 100, 0, 1'b0);
    add_request(OP_FREE, 4095, 0, 1'b0);
    add_request(OP_FREE, 4095, 0, 1'b0);
    add_request(OP_ALLOC, 0, 0, 1'b0);
    add_request(OP_ALLOC, 0, 0, 1'b0);
    add_request(OP_RESERVE, 10, 5, 1'b0);
    add_request(OP_RELEASE, 4000, 4096, 1'b0);
    add_request(OP_RELEASE, 0, 4096, 1'b0);
    add_request(OP_FREE, 0, 0, 1'b0);
    add_request(OP_ALLOC, 0, 0, 1'b0);
    add_request(OP_ALLOC, 0, 0, 1'b0);
    add_request(OP_FREE, 4095, 0, 1'b0);
    add_request(OP_RESERVE, 4095, 1, 1'b0);
    add_request(OP_RESERVE, 0, 8191, 1'b1);
    add_request(OP_RELEASE, 63, 2, 1'b0);
    add_request(OP_RELEASE, 2048, 64, 1'b0);
    add_request(OP_ALLOC, 0, 0, 1'b0);
    add_request(OP_ALLOC, 0, 0, 1'b0);
    add_request(OP_ALLOC, 0, 0, 1'b0);
    add_request(OP_FREE, 2100, 0, 1'b0);
    add_request(OP_ALLOC, 0, 0, 1'b0);
    add_request(OP_RESERVE, 4090, 6000, 1'b0);

    // random mix, mostly small regions near the low frames so allocations hit freed bits
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      sel = $urandom_range(0, 99);
      drain = (n % DRAIN_EVERY) == DRAIN_EVERY - 1;
      if (sel < 40) begin
        add_request(OP_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 8191), drain);
      end else if (sel < 62) begin
        idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 255);
        add_request(OP_FREE, idx, $urandom_range(0, 8191), drain);
      end else if (sel < 96) begin
        idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 511);
        cnt = $urandom_range(0, 64);
        add_request((sel < 80) ? OP_RELEASE : OP_RESERVE, idx, cnt, drain);
      end else if (sel < 98) begin
        add_request(sel[0] ? OP_RESERVE : OP_RELEASE, $urandom_range(0, 4095),
                    $urandom_range(0, 8191), drain);
      end else begin
        add_request(sel[0] ? OP_RESERVE : OP_RELEASE, 0, 4096, drain);
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (request_backlog.size() != 0 || words_issued != words_taken) @(posedge clk);
    wait_cycles = 0;
    while (awaited_replies.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (awaited_replies.size() != 0)
      flag_mismatch($sformatf("%0d replies never arrived", awaited_replies.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/bpfa_pkg.sv
src/bpfa_if.sv
src/bpfa_ram.sv
src/bitmap_page_frame_allocator.sv
src/bpfa_checker.sv
bench/bitmap_page_frame_allocator_tb.sv
